@@ hdl/five_channel_kalman_sensor_conditioner_macros.svh @@
// Assertion macros for the Kalman sensor conditioner; clk_i and rst_ni must be in scope.
`ifndef FIVE_CHANNEL_KALMAN_SENSOR_CONDITIONER_MACROS_SVH
`define FIVE_CHANNEL_KALMAN_SENSOR_CONDITIONER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define KSCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KSCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/kscd_pkg.sv @@
// Types and constants shared by the Kalman sensor conditioner modules.
`timescale 1ns / 1ps

package kscd_pkg;

  localparam int CHANNELS   = 5;
  localparam int MID_IDX    = CHANNELS / 2;
  localparam int SAMPLE_W   = 8;
  localparam int LVL_W      = 8;
  localparam int COV_W      = 17;
  localparam int PP_W       = COV_W + 1;
  localparam int DEN_W      = PP_W + 1;
  localparam int NOISE_W    = 16;
  localparam int THR_W      = 10;
  localparam int NORM_W     = 15;   // sample * 100 fits here
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [REG_IDX_W-1:0] REG_ADC_MAX       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PROCESS_NOISE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MEASURE_NOISE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INIT_COV      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOST_THR      = 3'd4;

  localparam logic [SAMPLE_W-1:0] ADC_MAX_RST = 8'd235;
  localparam logic [NOISE_W-1:0]  Q_RST       = 16'd66;
  localparam logic [NOISE_W-1:0]  R_RST       = 16'd35586;
  localparam logic [COV_W-1:0]    P0_RST      = 17'd1311;
  localparam logic [THR_W-1:0]    THR_RST     = 10'd100;
  localparam logic [COV_W-1:0]    COV_MAX     = 17'h1FFFF;
  localparam logic [LVL_W-1:0]    LVL_MAX     = 8'hFF;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_far_left;
    logic [SAMPLE_W-1:0] sample_left;
    logic [SAMPLE_W-1:0] sample_mid;
    logic [SAMPLE_W-1:0] sample_right;
    logic [SAMPLE_W-1:0] sample_far_right;
  } in_beat_t;

  typedef struct packed {
    logic [LVL_W-1:0] level_far_left;
    logic [LVL_W-1:0] level_left;
    logic [LVL_W-1:0] level_mid;
    logic [LVL_W-1:0] level_right;
    logic [LVL_W-1:0] level_far_right;
    logic             lost_flag;
  } out_beat_t;

endpackage

@@ hdl/kscd_div.sv @@
// Restoring divider, one quotient bit per cycle, with a preset partial remainder.
`timescale 1ns / 1ps

module kscd_div #(
  parameter int DVS_W = 8,
  parameter int NB    = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVS_W-1:0] rem0_i,   // must be below the divisor
  input  logic [NB-1:0]    dvd_i,    // bits shifted in, msb first
  input  logic [DVS_W-1:0] dvs_i,
  output logic [NB-1:0]    quo_o,
  output logic             done_o    // one-cycle pulse, quo_o is final
);

  localparam int CNT_W = $clog2(NB + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [NB-1:0]    dvd_q, dvd_d;
  logic [NB-1:0]    quo_q, quo_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;
  logic             last;
  logic             done_q;

  always_comb begin
    trial  = {rem_q, dvd_q[NB-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = trial >= {1'b0, dvs_q};
    last   = busy_q && (cnt_q == CNT_W'(1));

    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NB);
      rem_d  = rem0_i;
      dvs_d  = dvs_i;
      dvd_d  = dvd_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_d = {dvd_q[NB-2:0], 1'b0};
      quo_d = {quo_q[NB-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= last;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

@@ hdl/kscd_mul.sv @@
// Serial multiplier: floor(k * d / 2^(KW-1)), one bit of k per cycle, lsb first.
`timescale 1ns / 1ps

module kscd_mul #(
  parameter int DW = 25,
  parameter int KW = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] d_i,
  input  logic        [KW-1:0] k_i,    // at most 2^(KW-1)
  output logic signed [DW-1:0] prod_o,
  output logic                 done_o  // one-cycle pulse, prod_o is final
);

  localparam int CNT_W = $clog2(KW + 1);

  logic               busy_q, busy_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic signed [DW:0] acc_q, acc_d;
  logic signed [DW-1:0] d_q, d_d;
  logic [KW-1:0]      k_q, k_d;
  logic signed [DW:0] addend;
  logic signed [DW:0] sum;
  logic               last;
  logic               done_q;

  always_comb begin
    addend = k_q[0] ? {d_q[DW-1], d_q} : '0;
    sum    = acc_q + addend;
    last   = busy_q && (cnt_q == CNT_W'(1));

    busy_d = busy_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    d_d    = d_q;
    k_d    = k_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(KW);
      acc_d  = '0;
      d_d    = d_i;
      k_d    = k_i;
    end else if (busy_q) begin
      // arithmetic shift keeps the floor exact; top bit of k has weight one
      acc_d = last ? sum : (sum >>> 1);
      k_d   = k_q >> 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= last;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    d_q   <= d_d;
    k_q   <= k_d;
  end

  assign prod_o = signed'(acc_q[DW-1:0]);
  assign done_o = done_q;

endmodule

@@ hdl/five_channel_kalman_sensor_conditioner.sv @@
// Top level: five-channel scalar Kalman filter with normalization and lost-line flag.
`timescale 1ns / 1ps
`include "five_channel_kalman_sensor_conditioner_macros.svh"

// One beat in gives one beat out; the next beat is taken as soon as the engine
// has handed its result to the output register. The time is set by three
// bit-serial passes run one after another: the gain division, the estimate and
// covariance multiplies (all channels side by side) and the percent division
// (all channels side by side). Config writes are taken only while the engine is
// idle; a write of initial_covariance reloads the covariance at once, estimates
// are untouched.
module five_channel_kalman_sensor_conditioner #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  kscd_pkg::in_beat_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output kscd_pkg::out_beat_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [kscd_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  logic [kscd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int EW  = kscd_pkg::SAMPLE_W + FRAC_BITS;  // estimate, 8.F
  localparam int DW  = EW + 1;                          // signed innovation
  localparam int GW  = FRAC_BITS + 1;                   // gain, 0 .. 1.0
  localparam int CDW = kscd_pkg::PP_W + 1;              // signed covariance term
  localparam logic [GW-1:0] GainOne = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_GAIN   = 7'b0000010,
    S_MSTART = 7'b0000100,
    S_MUL    = 7'b0001000,
    S_NSTART = 7'b0010000,
    S_NORM   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [kscd_pkg::SAMPLE_W-1:0] adc_q;
  logic [kscd_pkg::NOISE_W-1:0]  q_q;
  logic [kscd_pkg::NOISE_W-1:0]  r_q;
  logic [kscd_pkg::THR_W-1:0]    thr_q;
  logic                          cfg_we;

  // filter state
  logic [kscd_pkg::COV_W-1:0]    cov_q, cov_d;
  logic [EW-1:0]                 est_q [kscd_pkg::CHANNELS];
  logic [EW-1:0]                 est_d [kscd_pkg::CHANNELS];

  // per-beat working registers
  logic [kscd_pkg::SAMPLE_W-1:0] smp_q [kscd_pkg::CHANNELS];
  logic [kscd_pkg::SAMPLE_W-1:0] smp_in [kscd_pkg::CHANNELS];
  logic [kscd_pkg::PP_W-1:0]     pp_q, pp_d;
  logic                          den_zero_q;
  logic [kscd_pkg::DEN_W-1:0]    den_d;
  logic [GW-1:0]                 gain_q;

  logic                          in_acc;
  logic                          out_free;
  logic                          out_valid_q;
  kscd_pkg::out_beat_t           out_q, out_d;

  // serial units
  logic [GW-1:0]                 gquo;
  logic                          gdone;
  logic                          mstart, nstart;
  logic                          mul_fin;
  logic signed [DW-1:0]          d_ch    [kscd_pkg::CHANNELS];
  logic signed [DW-1:0]          prod_ch [kscd_pkg::CHANNELS];
  logic signed [CDW-1:0]         d_cov, prod_cov;
  logic [kscd_pkg::CHANNELS:0]   mdone;     // top bit is the covariance lane
  logic [kscd_pkg::NORM_W-1:0]   ndvd [kscd_pkg::CHANNELS];
  logic [kscd_pkg::NORM_W-1:0]   nquo [kscd_pkg::CHANNELS];
  logic [kscd_pkg::CHANNELS-1:0] ndone;
  logic [kscd_pkg::SAMPLE_W-1:0] adc_eff;
  logic [kscd_pkg::LVL_W-1:0]    lvl [kscd_pkg::CHANNELS];
  logic [kscd_pkg::THR_W-1:0]    outer_sum;
  logic [kscd_pkg::PP_W-1:0]     pn;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign mstart      = (state_q == S_MSTART);
  assign nstart      = (state_q == S_NSTART);
  assign mul_fin     = (state_q == S_MUL) && mdone[kscd_pkg::CHANNELS];
  assign adc_eff     = (adc_q == '0) ? kscd_pkg::SAMPLE_W'(1) : adc_q;

  assign smp_in[0] = in_data_i.sample_far_left;
  assign smp_in[1] = in_data_i.sample_left;
  assign smp_in[2] = in_data_i.sample_mid;
  assign smp_in[3] = in_data_i.sample_right;
  assign smp_in[4] = in_data_i.sample_far_right;

  // predicted covariance and gain denominator
  always_comb begin
    pp_d  = kscd_pkg::PP_W'(cov_q) + kscd_pkg::PP_W'(q_q);
    den_d = kscd_pkg::DEN_W'(pp_d) + kscd_pkg::DEN_W'(r_q);
  end

  // gain = floor(pp * 2^F / den): remainder starts at pp >> 1, then pp[0] and F zeros
  kscd_div #(
    .DVS_W (kscd_pkg::DEN_W),
    .NB    (GW)
  ) u_gain_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_acc),
    .rem0_i (kscd_pkg::DEN_W'(pp_d[kscd_pkg::PP_W-1:1])),
    .dvd_i  ({pp_d[0], {FRAC_BITS{1'b0}}}),
    .dvs_i  (den_d),
    .quo_o  (gquo),
    .done_o (gdone)
  );

  // new P = pp - ceil(K * pp / 2^F), run as a multiply of K by -pp
  assign d_cov = -signed'({1'b0, pp_q});

  kscd_mul #(
    .DW(CDW),
    .KW(GW)
  ) u_cov_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mstart),
    .d_i    (d_cov),
    .k_i    (gain_q),
    .prod_o (prod_cov),
    .done_o (mdone[kscd_pkg::CHANNELS])
  );

  for (genvar gi = 0; gi < kscd_pkg::CHANNELS; gi++) begin : g_lane
    assign d_ch[gi] = signed'({1'b0, smp_q[gi], {FRAC_BITS{1'b0}}})
                    - signed'({1'b0, est_q[gi]});

    kscd_mul #(
      .DW(DW),
      .KW(GW)
    ) u_est_mul (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(mstart),
      .d_i    (d_ch[gi]),
      .k_i    (gain_q),
      .prod_o (prod_ch[gi]),
      .done_o (mdone[gi])
    );

    // whole part times 100 as shifts: 64 + 32 + 4
    assign ndvd[gi] =
        kscd_pkg::NORM_W'({est_q[gi][EW-1:FRAC_BITS], 6'b0})
      + kscd_pkg::NORM_W'({est_q[gi][EW-1:FRAC_BITS], 5'b0})
      + kscd_pkg::NORM_W'({est_q[gi][EW-1:FRAC_BITS], 2'b0});

    kscd_div #(
      .DVS_W(kscd_pkg::SAMPLE_W),
      .NB   (kscd_pkg::NORM_W)
    ) u_norm_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(nstart),
      .rem0_i ('0),
      .dvd_i  (ndvd[gi]),
      .dvs_i  (adc_eff),
      .quo_o  (nquo[gi]),
      .done_o (ndone[gi])
    );

    assign lvl[gi] = (|nquo[gi][kscd_pkg::NORM_W-1:kscd_pkg::LVL_W])
                   ? kscd_pkg::LVL_MAX : nquo[gi][kscd_pkg::LVL_W-1:0];
  end

  // the estimate stays between its old value and the sample, so wrapping is safe
  always_comb begin
    for (int i = 0; i < kscd_pkg::CHANNELS; i++) begin
      est_d[i] = est_q[i];
      if (mul_fin) begin
        est_d[i] = est_q[i] + prod_ch[i][EW-1:0];
      end
    end
  end

  always_comb begin
    pn    = pp_q + prod_cov[kscd_pkg::PP_W-1:0];
    cov_d = cov_q;
    if (cfg_we && cfg_index_i == kscd_pkg::REG_INIT_COV) begin
      cov_d = kscd_pkg::COV_W'(cfg_data_i);
    end else if (mul_fin) begin
      cov_d = pn[kscd_pkg::PP_W-1] ? kscd_pkg::COV_MAX : pn[kscd_pkg::COV_W-1:0];
    end
  end

  always_comb begin
    outer_sum = '0;
    for (int i = 0; i < kscd_pkg::CHANNELS; i++) begin
      if (i != kscd_pkg::MID_IDX) begin
        outer_sum = outer_sum + kscd_pkg::THR_W'(lvl[i]);
      end
    end
    out_d.level_far_left  = lvl[0];
    out_d.level_left      = lvl[1];
    out_d.level_mid       = lvl[2];
    out_d.level_right     = lvl[3];
    out_d.level_far_right = lvl[4];
    out_d.lost_flag       = outer_sum < thr_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = S_GAIN;
      S_GAIN:   if (gdone) state_d = S_MSTART;
      S_MSTART: state_d = S_MUL;
      S_MUL:    if (&mdone) state_d = S_NSTART;
      S_NSTART: state_d = S_NORM;
      S_NORM:   if (&ndone) state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      adc_q       <= kscd_pkg::ADC_MAX_RST;
      q_q         <= kscd_pkg::Q_RST;
      r_q         <= kscd_pkg::R_RST;
      thr_q       <= kscd_pkg::THR_RST;
      cov_q       <= kscd_pkg::P0_RST;
      for (int i = 0; i < kscd_pkg::CHANNELS; i++) begin
        est_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cov_q   <= cov_d;
      for (int i = 0; i < kscd_pkg::CHANNELS; i++) begin
        est_q[i] <= est_d[i];
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index_i)
          kscd_pkg::REG_ADC_MAX:       adc_q <= kscd_pkg::SAMPLE_W'(cfg_data_i);
          kscd_pkg::REG_PROCESS_NOISE: q_q   <= cfg_data_i;
          kscd_pkg::REG_MEASURE_NOISE: r_q   <= cfg_data_i;
          kscd_pkg::REG_LOST_THR:      thr_q <= kscd_pkg::THR_W'(cfg_data_i);
          default: ;  // initial_covariance goes straight to cov_q
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < kscd_pkg::CHANNELS; i++) begin
        smp_q[i] <= smp_in[i];
      end
      pp_q       <= pp_d;
      den_zero_q <= (den_d == '0);
    end
    if (state_q == S_GAIN && gdone) begin
      gain_q <= den_zero_q ? '0 : gquo;
    end
    if (state_q == S_DONE && out_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `KSCD_ASSERT_NOW(a_gain_le_one, state_q == S_MUL, gain_q <= GainOne, "gain above one")
  `KSCD_ASSERT_NOW(a_lanes_lockstep, state_q == S_MUL, (&mdone) || !(|mdone), "lanes out of step")
  `KSCD_ASSERT_NOW(a_cov_not_above_pp, mul_fin, pn <= pp_q, "covariance grew past prediction")
  `KSCD_ASSERT_NOW(a_out_from_done, $rose(out_valid_q), $past(state_q == S_DONE), "stray result beat")

endmodule
